### sv/assert_macros.svh
// Assertion macros for the PCM playback buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication checked at every clock edge out of reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/pcmpb_pkg.sv
// Shared types, constants and helpers for the PCM playback buffer controller.
package pcmpb_pkg;

	// FIFO geometry
	localparam int DEPTH    = 4096;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int LEVEL_W  = 13;
	localparam int SAMPLE_W = 16;

	// Gain path: magnitude * (50 + 3*vol), then /100 by reciprocal multiply
	localparam int GAIN_W      = 9;
	localparam int MAG_W       = 24;
	localparam int QUO_W       = 17;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP = 25'd21474837; // ceil(2^31 / 100)

	localparam logic [6:0] VOL_MAX = 7'd100;

	// Register reset values
	localparam logic [6:0]  VOLUME_RST   = 7'd70;
	localparam logic [12:0] PREFETCH_RST = 13'd1024;
	localparam logic [7:0]  DRAIN_RST    = 8'd50;
	localparam logic [9:0]  TAIL_RST     = 10'd500;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_CHUNK = 2'd1,
		OP_TICK  = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_START   = 2'd1,
		EV_IDLE    = 2'd2,
		EV_TIMEOUT = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		CFG_VOLUME   = 2'd0,
		CFG_PREFETCH = 2'd1,
		CFG_DRAIN    = 2'd2,
		CFG_TAIL     = 2'd3
	} cfg_idx_t;

	// Control word traveling down the pipeline beside the sample
	typedef struct packed {
		logic valid;
		op_t  op;
		logic stream_end;
	} stage_t;

	// Configuration register set
	typedef struct packed {
		logic [6:0]  volume;
		logic [12:0] prefetch;
		logic [7:0]  drain;
		logic [9:0]  tail;
	} cfg_t;

	// Circular index advance
	function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] i);
		logic [ADDR_W-1:0] r;
		r = (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
		return r;
	endfunction

endpackage

### sv/pcmpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcmpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/pcmpb_scale.sv
// Input register and gain pipeline: scale by (50+3*vol)/100, truncate, saturate.
module pcmpb_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  pcmpb_pkg::stage_t                   in_stage,
	input  logic signed [pcmpb_pkg::SAMPLE_W-1:0] in_sample,
	input  logic [6:0]                          volume,
	output pcmpb_pkg::stage_t                   out_stage,
	output logic signed [pcmpb_pkg::SAMPLE_W-1:0] out_sample
);

	localparam int PROD_W = pcmpb_pkg::MAG_W + pcmpb_pkg::RECIP_W;

	logic                                  valid_s1, valid_s2, valid_s3;
	pcmpb_pkg::op_t                        op_s1, op_s2, op_s3;
	logic                                  stream_end_s1, stream_end_s2, stream_end_s3;
	logic signed [pcmpb_pkg::SAMPLE_W-1:0] sample_s1;
	logic [pcmpb_pkg::MAG_W-1:0]           mag_s2;
	logic                                  neg_s2, neg_s3;
	logic [pcmpb_pkg::QUO_W-1:0]           quo_s3;

	logic [6:0]                            vol_clamped;
	logic [pcmpb_pkg::GAIN_W-1:0]          gain;
	logic [pcmpb_pkg::SAMPLE_W-1:0]        mag_in;
	logic [pcmpb_pkg::MAG_W-1:0]           mag_prod;
	logic [PROD_W-1:0]                     recip_prod;
	logic [pcmpb_pkg::QUO_W-1:0]           quo;

	// stage 1: magnitude times gain
	always_comb begin
		vol_clamped = (volume > pcmpb_pkg::VOL_MAX) ? pcmpb_pkg::VOL_MAX : volume;
		gain        = pcmpb_pkg::GAIN_W'(50) + pcmpb_pkg::GAIN_W'(3) * {2'b00, vol_clamped};
		mag_in      = sample_s1[pcmpb_pkg::SAMPLE_W-1] ? pcmpb_pkg::SAMPLE_W'(-sample_s1)
		                                               : pcmpb_pkg::SAMPLE_W'(sample_s1);
		mag_prod    = pcmpb_pkg::MAG_W'(mag_in) * pcmpb_pkg::MAG_W'(gain);
	end

	// stage 2: divide by 100 through the reciprocal (exact for 24-bit magnitudes)
	always_comb begin
		recip_prod = PROD_W'(mag_s2) * PROD_W'(pcmpb_pkg::RECIP);
		quo        = recip_prod[pcmpb_pkg::RECIP_SHIFT +: pcmpb_pkg::QUO_W];
	end

	// stage 3: restore sign and saturate to 16 bits
	always_comb begin
		if (neg_s3) begin
			if (quo_s3 > pcmpb_pkg::QUO_W'(32768)) begin
				out_sample = 16'sh8000;
			end else begin
				out_sample = pcmpb_pkg::SAMPLE_W'(-quo_s3);
			end
		end else begin
			if (quo_s3 > pcmpb_pkg::QUO_W'(32767)) begin
				out_sample = 16'sh7FFF;
			end else begin
				out_sample = pcmpb_pkg::SAMPLE_W'(quo_s3);
			end
		end
	end

	assign out_stage = pcmpb_pkg::stage_t'({valid_s3, op_s3, stream_end_s3});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_stage.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1         <= in_stage.op;
			stream_end_s1 <= in_stage.stream_end;
			sample_s1     <= in_sample;
			op_s2         <= op_s1;
			stream_end_s2 <= stream_end_s1;
			mag_s2        <= mag_prod;
			neg_s2        <= sample_s1[pcmpb_pkg::SAMPLE_W-1];
			op_s3         <= op_s2;
			stream_end_s3 <= stream_end_s2;
			quo_s3        <= quo;
			neg_s3        <= neg_s2;
		end
	end

endmodule

### sv/pcmpb_ctrl.sv
// FIFO pointers, play/idle controller and result register.
module pcmpb_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  pcmpb_pkg::stage_t                     stage,
	input  logic signed [pcmpb_pkg::SAMPLE_W-1:0] sample,
	input  pcmpb_pkg::cfg_t                       cfg,
	output logic                                  res_valid,
	output logic                                  sample_valid,
	output logic signed [pcmpb_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                  push_dropped,
	output pcmpb_pkg::ev_t                        event_res,
	output logic                                  playing,
	output logic [pcmpb_pkg::LEVEL_W-1:0]         fill_level
);

	localparam int AW = pcmpb_pkg::ADDR_W;
	localparam int LW = pcmpb_pkg::LEVEL_W;

	// controller state
	logic [AW-1:0] wr_idx_q, rd_idx_q;
	logic [LW-1:0] level_q;
	logic          playing_q, expect_q;
	logic [7:0]    idle_q;
	logic [9:0]    tail_q;

	// next state
	logic [AW-1:0] wr_idx_n, rd_idx_n;
	logic [LW-1:0] level_n;
	logic          playing_n, expect_n;
	logic [7:0]    idle_n;
	logic [9:0]    tail_n;
	logic [8:0]    idle_inc;
	logic [10:0]   tail_inc;
	logic          counted;
	logic          emit, drop, wr_en;
	pcmpb_pkg::ev_t ev;

	// result stage
	logic           emit_s4, drop_s4, playing_s4;
	pcmpb_pkg::ev_t ev_s4;
	logic [LW-1:0]  level_s4;
	logic [pcmpb_pkg::SAMPLE_W-1:0] rd_data;

	// one controller step per item
	always_comb begin
		wr_idx_n  = wr_idx_q;
		rd_idx_n  = rd_idx_q;
		level_n   = level_q;
		playing_n = playing_q;
		expect_n  = expect_q;
		idle_n    = idle_q;
		tail_n    = tail_q;
		idle_inc  = {1'b0, idle_q} + 9'd1;
		tail_inc  = {1'b0, tail_q} + 11'd1;
		counted   = 1'b0;
		emit      = 1'b0;
		drop      = 1'b0;
		wr_en     = 1'b0;
		ev        = pcmpb_pkg::EV_NONE;
		case (stage.op)
			pcmpb_pkg::OP_PUSH, pcmpb_pkg::OP_CHUNK: begin
				if (stage.op == pcmpb_pkg::OP_CHUNK) begin
					expect_n = !stage.stream_end;
				end
				if (level_q >= LW'(pcmpb_pkg::DEPTH)) begin
					drop = 1'b1;
				end else begin
					wr_en    = 1'b1;
					wr_idx_n = pcmpb_pkg::next_idx(wr_idx_q);
					level_n  = level_q + LW'(1);
				end
			end
			pcmpb_pkg::OP_END: begin
				expect_n = 1'b0;
			end
			pcmpb_pkg::OP_TICK: begin
				if (level_q == '0) begin
					// empty tick: tail timeout first, then drain count
					if (playing_q) begin
						counted = 1'b1;
						if (expect_q) begin
							if (tail_inc >= {1'b0, cfg.tail}) begin
								expect_n = 1'b0;
								tail_n   = '0;
								ev       = pcmpb_pkg::EV_TIMEOUT;
							end else begin
								tail_n  = tail_inc[9:0];
								counted = 1'b0;
							end
						end
						if (counted) begin
							if (idle_inc >= {1'b0, cfg.drain}) begin
								playing_n = 1'b0;
								idle_n    = '0;
								expect_n  = 1'b0;
								tail_n    = '0;
								ev        = pcmpb_pkg::EV_IDLE;
							end else begin
								idle_n = idle_inc[7:0];
							end
						end
					end else begin
						tail_n = '0;
					end
				end else begin
					// samples held: maybe start, then emit
					idle_n = '0;
					tail_n = '0;
					emit   = 1'b1;
					if (!playing_q) begin
						if (expect_q && level_q < cfg.prefetch) begin
							emit = 1'b0;
						end else begin
							playing_n = 1'b1;
							ev        = pcmpb_pkg::EV_START;
						end
					end
					if (emit) begin
						rd_idx_n = pcmpb_pkg::next_idx(rd_idx_q);
						level_n  = level_q - LW'(1);
					end
				end
			end
			default: begin
				expect_n = expect_q;
			end
		endcase
	end

	pcmpb_ram #(
		.WIDTH(pcmpb_pkg::SAMPLE_W),
		.DEPTH(pcmpb_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (adv && stage.valid && wr_en),
		.wr_addr(wr_idx_q),
		.wr_data(sample),
		.rd_en  (adv && stage.valid && emit),
		.rd_addr(rd_idx_q),
		.rd_data(rd_data)
	);

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			level_q   <= '0;
			playing_q <= 1'b0;
			expect_q  <= 1'b0;
			idle_q    <= '0;
			tail_q    <= '0;
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= stage.valid;
			if (stage.valid) begin
				wr_idx_q  <= wr_idx_n;
				rd_idx_q  <= rd_idx_n;
				level_q   <= level_n;
				playing_q <= playing_n;
				expect_q  <= expect_n;
				idle_q    <= idle_n;
				tail_q    <= tail_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s4    <= emit;
			drop_s4    <= drop;
			ev_s4      <= ev;
			playing_s4 <= playing_n;
			level_s4   <= level_n;
		end
	end

	assign sample_valid = emit_s4;
	assign sample_out   = emit_s4 ? rd_data : '0;
	assign push_dropped = drop_s4;
	assign event_res    = ev_s4;
	assign playing      = playing_s4;
	assign fill_level   = level_s4;

endmodule

### sv/pcm_playback_buffer_controller_core.sv
// Top level of the PCM playback buffer controller: ports, config registers, pipeline.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata sample_in, tlast stream_end, tuser op
// m_*       out  m_tvalid/m_tready  tdata result word (see port comment)
// cfg_*     in   cfg_valid/cfg_ready cfg_addr register index, cfg_data value
//
// One word per cycle sustained while results are taken; each result is offered once its word
// has passed the input register, gain multiply and reciprocal divide stages, and saturation
// and the controller step have loaded the result register.
// The whole pipeline holds while a result waits on m_tready.
// Reset clears FIFO pointers, controller state and configuration; the sample
// RAM is not cleared and needs no sweep, so words are taken right after reset.
`include "assert_macros.svh"

module pcm_playback_buffer_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample_in
	input  logic        s_tlast,  // stream_end
	input  logic [1:0]  s_tuser,  // [1:0] op
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [0] sample_valid, [16:1] sample_out, [17] push_dropped,
	                              // [19:18] event_res, [20] playing, [33:21] fill_level
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_data
);

	logic                     adv;
	pcmpb_pkg::cfg_t          cfg_q;
	pcmpb_pkg::stage_t        in_stage, scaled_stage;
	logic signed [15:0]       scaled_sample;
	logic                     sample_valid, push_dropped, playing;
	logic signed [15:0]       sample_out;
	pcmpb_pkg::ev_t           event_res;
	logic [12:0]              fill_level;

	// pipeline moves whenever the result register is free or being taken
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	assign in_stage = pcmpb_pkg::stage_t'({s_tvalid, s_tuser, s_tlast});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume   <= pcmpb_pkg::VOLUME_RST;
			cfg_q.prefetch <= pcmpb_pkg::PREFETCH_RST;
			cfg_q.drain    <= pcmpb_pkg::DRAIN_RST;
			cfg_q.tail     <= pcmpb_pkg::TAIL_RST;
		end else if (cfg_valid) begin
			case (pcmpb_pkg::cfg_idx_t'(cfg_addr))
				pcmpb_pkg::CFG_VOLUME:   cfg_q.volume   <= cfg_data[6:0];
				pcmpb_pkg::CFG_PREFETCH: cfg_q.prefetch <= cfg_data;
				pcmpb_pkg::CFG_DRAIN:    cfg_q.drain    <= cfg_data[7:0];
				pcmpb_pkg::CFG_TAIL:     cfg_q.tail     <= cfg_data[9:0];
				default:                 cfg_q          <= cfg_q;
			endcase
		end
	end

	pcmpb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_stage  (in_stage),
		.in_sample (s_tdata),
		.volume    (cfg_q.volume),
		.out_stage (scaled_stage),
		.out_sample(scaled_sample)
	);

	pcmpb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.stage       (scaled_stage),
		.sample      (scaled_sample),
		.cfg         (cfg_q),
		.res_valid   (m_tvalid),
		.sample_valid(sample_valid),
		.sample_out  (sample_out),
		.push_dropped(push_dropped),
		.event_res   (event_res),
		.playing     (playing),
		.fill_level  (fill_level)
	);

	assign m_tdata = {6'b0, fill_level, playing, event_res, push_dropped,
	                  sample_out, sample_valid};

	// checks
	`ASSERT_ALWAYS(a_level_bound, !m_tvalid || (fill_level <= 13'(pcmpb_pkg::DEPTH)), "fill level above depth")
	`ASSERT_IMPLY(a_silent_zero, m_tvalid && !sample_valid, sample_out == 16'sd0, "sample without valid")
	`ASSERT_IMPLY(a_drop_full, m_tvalid && push_dropped, fill_level == 13'(pcmpb_pkg::DEPTH), "drop while not full")
	`ASSERT_IMPLY(a_start_plays, m_tvalid && (event_res == pcmpb_pkg::EV_START), playing && sample_valid, "start without play")
	`ASSERT_IMPLY(a_idle_stops, m_tvalid && (event_res == pcmpb_pkg::EV_IDLE), !playing && (fill_level == 13'd0), "idle while playing")

endmodule

### tb/tb.sv
// Self-checking testbench for the PCM playback buffer controller core.
`timescale 1ns / 100ps

import pcmpb_pkg::*;

localparam int MAX_SHOWN = 10;

// One result word as it leaves the block, lowest field last
typedef struct packed {
	logic [LEVEL_W-1:0]  fill;
	logic                playing;
	ev_t                 ev;
	logic                dropped;
	logic [SAMPLE_W-1:0] smp;
	logic                valid;
} result_t;

// Predicts each result from the accepted words and checks the output stream
class pcm_scoreboard;
	logic [SAMPLE_W-1:0] ram [DEPTH];
	int unsigned wr_ptr, rd_ptr, level;
	bit          playing, more;
	int unsigned idle_cnt, tail_cnt;
	int unsigned volume, prefetch, drain, tail_lim;
	result_t     expected_results [$];
	int unsigned words_in, words_out, played, dropped, starts, idles, timeouts;
	int unsigned errors;

	function new();
		wr_ptr   = 0;
		rd_ptr   = 0;
		level    = 0;
		playing  = 1'b0;
		more     = 1'b0;
		idle_cnt = 0;
		tail_cnt = 0;
		volume   = VOLUME_RST;
		prefetch = PREFETCH_RST;
		drain    = DRAIN_RST;
		tail_lim = TAIL_RST;
		errors   = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [12:0] val);
		case (idx)
		CFG_VOLUME:   volume   = val[6:0];
		CFG_PREFETCH: prefetch = val;
		CFG_DRAIN:    drain    = val[7:0];
		CFG_TAIL:     tail_lim = val[9:0];
		default:      ;
		endcase
	endfunction

	// gain (50 + 3*vol)/100, truncated toward zero, then saturated
	function logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] raw);
		int s, v, p;
		s = int'($signed(raw));
		v = (volume > VOL_MAX) ? VOL_MAX : volume;
		p = (s * (50 + 3 * v)) / 100;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return p[SAMPLE_W-1:0];
	endfunction

	// Accepted input word: advance the predicted state, queue the result
	function void note_input(op_t op, logic [SAMPLE_W-1:0] raw, logic last);
		result_t r;
		bit      counted, go;
		r = '0;
		words_in++;
		case (op)
		OP_PUSH, OP_CHUNK: begin
			if (op == OP_CHUNK)
				more = !last;
			if (level >= DEPTH) begin
				r.dropped = 1'b1;
				dropped++;
			end else begin
				ram[wr_ptr] = apply_gain(raw);
				wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
				level++;
			end
		end
		OP_END: more = 1'b0;
		default: begin
			if (level == 0) begin
				// empty tick: tail timeout first, then the drain count
				if (playing) begin
					counted = 1'b1;
					if (more) begin
						tail_cnt++;
						if (tail_cnt >= tail_lim) begin
							more     = 1'b0;
							tail_cnt = 0;
							r.ev     = EV_TIMEOUT;
						end else begin
							counted = 1'b0;
						end
					end
					if (counted) begin
						idle_cnt++;
						if (idle_cnt >= drain) begin
							playing  = 1'b0;
							idle_cnt = 0;
							more     = 1'b0;
							tail_cnt = 0;
							r.ev     = EV_IDLE;
						end
					end
				end else begin
					tail_cnt = 0;
				end
			end else begin
				// samples waiting: start unless still prefetching
				go       = 1'b1;
				idle_cnt = 0;
				tail_cnt = 0;
				if (!playing) begin
					if (more && level < prefetch) begin
						go = 1'b0;
					end else begin
						playing = 1'b1;
						r.ev    = EV_START;
					end
				end
				if (go) begin
					r.smp   = ram[rd_ptr];
					r.valid = 1'b1;
					rd_ptr  = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
					level--;
					played++;
				end
			end
		end
		endcase
		case (r.ev)
		EV_START:   starts++;
		EV_IDLE:    idles++;
		EV_TIMEOUT: timeouts++;
		default:    ;
		endcase
		r.playing = playing;
		r.fill    = level[LEVEL_W-1:0];
		expected_results.push_back(r);
	endfunction

	// Accepted output word: compare with the oldest expected result
	function void check_word(logic [39:0] word);
		result_t got, want;
		got = result_t'(word[33:0]);
		words_out++;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("ERROR: result word %h with nothing expected", word);
			return;
		end
		want = expected_results.pop_front();
		if (got !== want || word[39:34] !== '0) begin
			errors++;
			if (errors <= MAX_SHOWN) begin
				$display("ERROR: result %0d exp valid=%0b smp=%0d drop=%0b ev=%0d play=%0b fill=%0d",
					words_out, want.valid, $signed(want.smp), want.dropped, want.ev,
					want.playing, want.fill);
				$display("       got valid=%0b smp=%0d drop=%0b ev=%0d play=%0b fill=%0d pad=%h",
					got.valid, $signed(got.smp), got.dropped, got.ev, got.playing, got.fill,
					word[39:34]);
			end
		end
	endfunction
endclass

module tb;
	localparam int LIMIT       = 1_000_000;
	localparam int PHASE_ITEMS = 330;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_addr;
	logic [12:0] cfg_data;

	int unsigned send_idle_pct = 14;
	int unsigned recv_idle_pct = 59;
	int unsigned cycles        = 0;
	int unsigned settings_used = 0;
	int unsigned leftover;

	pcm_scoreboard sb = new();

	pcm_playback_buffer_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycles,
				sb.expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// result checking
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// Send one input word, with random gaps ahead of it
	task automatic send_item(op_t op, logic [15:0] smp, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk) s_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= op;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, smp, last);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic load_settings(logic [12:0] vol, logic [12:0] pre, logic [12:0] drn,
			logic [12:0] tl);
		write_reg(CFG_VOLUME, vol);
		write_reg(CFG_PREFETCH, pre);
		write_reg(CFG_DRAIN, drn);
		write_reg(CFG_TAIL, tl);
		@(negedge clk) cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Hold the sender until every expected result is back, then settle
	task automatic drain_all();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly chunks of pushes and tick runs, some end-stream and noise words
	task automatic run_random(int unsigned n);
		int unsigned sent, kind, k, long_run;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				send_item(OP_CHUNK, rand_sample(), $urandom_range(7) == 0);
				sent++;
				k = $urandom_range(1, 24);
				repeat (k) begin
					send_item(OP_PUSH, rand_sample(), 1'($urandom_range(1)));
					sent++;
					if ($urandom_range(2) == 0) begin
						send_item(OP_TICK, rand_sample(), 1'($urandom_range(1)));
						sent++;
					end
				end
			end else if (kind < 80) begin
				// now and then a run long enough to time out and go idle, kept short
				long_run = sb.drain + sb.tail_lim + 2;
				if (long_run > 200)
					long_run = 200;
				k = ($urandom_range(15) == 0) ? long_run : $urandom_range(1, 40);
				repeat (k) begin
					send_item(OP_TICK, rand_sample(), 1'($urandom_range(1)));
					sent++;
				end
			end else if (kind < 90) begin
				send_item(OP_END, rand_sample(), 1'($urandom_range(1)));
				sent++;
				k = $urandom_range(1, 4);
				repeat (k) begin
					send_item(OP_TICK, rand_sample(), 1'($urandom_range(1)));
					sent++;
				end
			end else begin
				send_item(op_t'($urandom_range(OP_END)), rand_sample(), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		s_tuser   = OP_PUSH;
		cfg_valid = 1'b0;
		cfg_addr  = CFG_VOLUME;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: full gain, short drain, immediate tail timeout
		load_settings(13'd100, 13'd1024, 13'd2, 13'd1);
		send_item(OP_PUSH, 16'h7FFF, 1'b0);
		send_item(OP_PUSH, 16'h8000, 1'b1);
		send_item(OP_PUSH, 16'h0000, 1'b0);
		send_item(OP_CHUNK, 16'hFFFF, 1'b1);
		send_item(OP_PUSH, 16'h0001, 1'b0);
		// start with nothing more expected, play out, drain to idle, idle empty tick
		repeat (8) send_item(OP_TICK, 16'h0000, 1'b0);
		// prefetch hold, released by end of stream
		send_item(OP_CHUNK, 16'h3039, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_END, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		// tail timeout alone, then idle on the following tick
		send_item(OP_CHUNK, 16'h0064, 1'b0);
		repeat (3) send_item(OP_TICK, 16'h0000, 1'b0);
		drain_all();

		// volume above range, timeout and idle on the same tick
		load_settings(13'd127, 13'd2, 13'd1, 13'd1);
		send_item(OP_CHUNK, 16'hFFFD, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_PUSH, 16'h0003, 1'b0);
		repeat (3) send_item(OP_TICK, 16'h0000, 1'b0);
		drain_all();

		// random phases over several register settings and idling patterns
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle_pct = 59;
				recv_idle_pct = 14;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
			0: load_settings(13'd127, 13'd16, 13'd8, 13'd20);
			1: load_settings(13'd0, 13'd0, 13'd1, 13'd1);
			2: load_settings(13'd100, 13'd3072, 13'd255, 13'd1023);
			4: load_settings(13'd50, 13'd1, 13'd0, 13'd0);
			default: load_settings(13'($urandom_range(127)), 13'($urandom_range(100)),
				13'($urandom_range(30)), 13'($urandom_range(60)));
			endcase
			run_random(PHASE_ITEMS);
			drain_all();
		end

		$display("Run covered %0d words in and %0d results over %0d register settings",
			sb.words_in, sb.words_out, settings_used);
		$display("%0d samples played, %0d pushes dropped, %0d starts, %0d idles, %0d timeouts",
			sb.played, sb.dropped, sb.starts, sb.idles, sb.timeouts);
		leftover = sb.expected_results.size();
		if (leftover != 0)
			$display("ERROR: %0d expected results never arrived", leftover);
		if (sb.errors == 0 && leftover == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### pcm_playback_buffer_controller_core.f
+incdir+sv
sv/pcmpb_pkg.sv
sv/pcmpb_ram.sv
sv/pcmpb_scale.sv
sv/pcmpb_ctrl.sv
sv/pcm_playback_buffer_controller_core.sv
tb/tb.sv
